### hdl/gso_pkg.sv
// Shared types and constants for the Gram-Schmidt orthonormaliser.
// No dependencies; imported by gram_schmidt_orthonormalizer_unit and its testbench.
`timescale 1ns / 1ps

package gso_pkg;

    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 4;
    localparam int IN_W       = 32;
    localparam int OUT_DATA_W = 40;
    localparam int WORK_W     = 48;
    localparam int PROD_W     = 80;
    localparam int ACC_W      = 56;

    localparam logic [CFG_IDX_W-1:0] CFG_VCOUNT = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VLEN   = 4'd1;

    localparam logic [CFG_DATA_W-1:0] CFG_RESET_VALUE = 4'd8;

    localparam logic [WORK_W-1:0] NORM_HI = 48'h0000_4000_0000;
    localparam logic [WORK_W-1:0] NORM_LO = 48'h0000_2000_0000;

    localparam logic [5:0] SQRT_LAST = 6'd31;
    localparam logic [5:0] DIV_LAST  = 6'd62;

    typedef enum logic [4:0] {
        S_IDLE,
        S_LD_RD,
        S_LD_WR,
        S_DOT_RD,
        S_DOT_MUL,
        S_DOT_ACC,
        S_UPD_RD,
        S_UPD_MUL,
        S_UPD_WR,
        S_MAX,
        S_SCALE,
        S_SQ_MUL,
        S_SQ_ACC,
        S_SQRT,
        S_DIV,
        S_OUT_MUL,
        S_OUT_LATCH,
        S_OUT_SEND
    } gso_state_t;

endpackage

### hdl/gram_schmidt_orthonormalizer_unit.sv
// Modified Gram-Schmidt orthonormaliser: loader, sequencer and shared datapath.
// Depends on gso_pkg for the state type and fixed constants.
`timescale 1ns / 1ps

// How to use this block.
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data. Index 0 sets the vector
// count and index 1 the vector length (0 acts as 1, values above the maximum are clipped).
// Any write to either register drops a partly loaded set. cfg_ready is always high.
// Input: each s_ item is one signed Q16.16 component, vector 0 first, element by element.
// s_tready is high only while loading, when the block takes one item per cycle.
// The item completing the set starts the computation: for each vector the components are
// fetched, projections onto all earlier unit vectors are removed, the largest magnitude is
// found, the vector is brought into range by up to 29 single-bit shifts and a final check,
// the squared norm is accumulated, then a 32-step square root and a 63-step restoring
// division give the reciprocal norm, and every component is scaled, latched and sent.
// The run time is dominated by the single shared 48x17 multiplier and the bit-serial
// root and divider.
// Output: one m_ item per component in signed Q2.30, with vector and element indices,
// m_tuser flagging a zero-norm vector and m_tlast on the final component of the set.
// If the receiver stalls, the sequencer simply holds on the waiting item.
// Reset (aresetn low at a clock edge) returns both registers to 8, empties the loader and
// abandons any set in progress; the vector stores need no clearing.
module gram_schmidt_orthonormalizer_unit #(
    parameter int MAX_VECTORS = 8,
    parameter int MAX_LENGTH  = 8
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [gso_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [gso_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // s_tdata, from bit 0: component[31:0]
    input  logic [gso_pkg::IN_W-1:0]        s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // m_tdata, from bit 0: unit_component[31:0], vector_index[34:32],
    // element_index[37:35], zero padding[39:38]
    output logic [gso_pkg::OUT_DATA_W-1:0]  m_tdata,
    // m_tuser, from bit 0: degenerate
    output logic                            m_tuser,
    output logic                            m_tlast
);
    import gso_pkg::*;

    localparam int VW    = (MAX_VECTORS > 1) ? $clog2(MAX_VECTORS) : 1;
    localparam int LW    = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;
    localparam int AW    = VW + LW;
    localparam int DEPTH = 1 << AW;

    // Saturate to 48 bits signed: all bits above bit 47 must match it.
    function automatic logic signed [WORK_W-1:0] sat48(input logic [ACC_W-1:0] x);
        logic signed [WORK_W-1:0] r;
        if ((&x[ACC_W-1:WORK_W-1]) || !(|x[ACC_W-1:WORK_W-1])) begin
            r = x[WORK_W-1:0];
        end else if (x[ACC_W-1]) begin
            r = {1'b1, {(WORK_W-1){1'b0}}};
        end else begin
            r = {1'b0, {(WORK_W-1){1'b1}}};
        end
        return r;
    endfunction

    function automatic logic [31:0] sat32(input logic [WORK_W-1:0] x);
        logic [31:0] r;
        if ((&x[WORK_W-1:31]) || !(|x[WORK_W-1:31])) begin
            r = x[31:0];
        end else if (x[WORK_W-1]) begin
            r = 32'h8000_0000;
        end else begin
            r = 32'h7FFF_FFFF;
        end
        return r;
    endfunction

    gso_state_t state_reg, state_next;

    logic [CFG_DATA_W-1:0] vcount_reg, vcount_next, vlen_reg, vlen_next;
    logic [VW-1:0] load_vec_reg, load_vec_next, vi_reg, vi_next, k_reg, k_next;
    logic [LW-1:0] load_elem_reg, load_elem_next, j_reg, j_next;
    logic          half_reg, half_next;
    logic [64:0]   prod_lo_reg, prod_lo_next;
    logic [PROD_W-1:0] prod_reg, prod_next;
    logic [ACC_W-1:0]  acc_reg, acc_next;
    logic signed [WORK_W-1:0] d_reg, d_next;
    logic [WORK_W-1:0] m_reg, m_next;
    logic [63:0]   s_reg, s_next;
    logic [34:0]   rem_reg, rem_next;
    logic [31:0]   root_reg, root_next;
    logic [33:0]   quo_reg, quo_next;
    logic [5:0]    iter_reg, iter_next;
    logic          degen_reg, degen_next;
    logic signed [WORK_W-1:0] work_reg [MAX_LENGTH];
    logic signed [WORK_W-1:0] work_next [MAX_LENGTH];
    logic [31:0]   out_data_reg, out_data_next;
    logic [2:0]    out_vidx_reg, out_vidx_next, out_eidx_reg, out_eidx_next;
    logic          out_degen_reg, out_degen_next, out_last_reg, out_last_next;
    logic          out_valid_reg, out_valid_next;

    // Vector stores: input components (Q16.16) and finished unit vectors (Q2.30).
    logic [31:0] in_mem [DEPTH];
    logic [31:0] bas_mem [DEPTH];
    logic [31:0] in_rdata_reg, bas_rdata_reg;
    logic        bas_we;

    logic cfg_acc, s_acc;
    logic [CFG_DATA_W-1:0] nv, nl;
    logic [VW-1:0] nv_last;
    logic [LW-1:0] nl_last;
    logic j_last, vi_last, k_last, load_elem_last, load_vec_last;

    logic signed [WORK_W-1:0] mul_a, wj;
    logic signed [31:0] mul_b;
    logic signed [16:0] mul_b17;
    logic signed [64:0] mprod;
    logic [49:0]  term;
    logic [ACC_W-1:0] acc_sum, upd_diff;
    logic [WORK_W-1:0] abs_w;
    logic [34:0]  sq_rem;
    logic [33:0]  sq_trial;
    logic [32:0]  dv_rem;

    assign cfg_ready = 1'b1;
    assign cfg_acc   = cfg_valid && cfg_ready;
    assign s_tready  = (state_reg == S_IDLE);
    assign s_acc     = s_tvalid && s_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_eidx_reg, out_vidx_reg, out_data_reg};
    assign m_tuser  = out_degen_reg;
    assign m_tlast  = out_last_reg;

    // Effective set shape; a zero register acts as one, a large one is clipped.
    always_comb begin
        if (vcount_reg == '0) begin
            nv = 4'd1;
        end else if (vcount_reg > CFG_DATA_W'(MAX_VECTORS)) begin
            nv = CFG_DATA_W'(MAX_VECTORS);
        end else begin
            nv = vcount_reg;
        end
        if (vlen_reg == '0) begin
            nl = 4'd1;
        end else if (vlen_reg > CFG_DATA_W'(MAX_LENGTH)) begin
            nl = CFG_DATA_W'(MAX_LENGTH);
        end else begin
            nl = vlen_reg;
        end
    end

    assign nv_last        = VW'(nv - 4'd1);
    assign nl_last        = LW'(nl - 4'd1);
    assign j_last         = (j_reg == nl_last);
    assign vi_last        = (vi_reg == nv_last);
    assign k_last         = (k_reg == VW'(vi_reg - VW'(1)));
    assign load_elem_last = (load_elem_reg == nl_last);
    assign load_vec_last  = (load_vec_reg == nv_last);

    assign wj = work_reg[j_reg];

    // Shared multiplier operands: the 32-bit factor goes in two 16-bit halves.
    always_comb begin
        unique case (state_reg)
            S_UPD_MUL: begin
                mul_a = d_reg;
                mul_b = bas_rdata_reg;
            end
            S_SQ_MUL: begin
                mul_a = wj;
                mul_b = wj[31:0];
            end
            S_OUT_MUL: begin
                mul_a = {14'b0, quo_reg};
                mul_b = wj[31:0];
            end
            default: begin
                mul_a = wj;
                mul_b = bas_rdata_reg;
            end
        endcase
    end

    assign mul_b17 = half_reg ? {mul_b[31], mul_b[31:16]} : {1'b0, mul_b[15:0]};
    assign mprod   = mul_a * mul_b17;

    assign term     = prod_reg[79:30];
    assign acc_sum  = acc_reg + {{(ACC_W-50){term[49]}}, term};
    assign upd_diff = {{(ACC_W-WORK_W){wj[WORK_W-1]}}, wj} - {{(ACC_W-50){term[49]}}, term};
    assign abs_w    = wj[WORK_W-1] ? WORK_W'(-wj) : WORK_W'(wj);
    assign sq_rem   = {rem_reg[32:0], s_reg[63:62]};
    assign sq_trial = {root_reg, 2'b01};
    assign dv_rem   = {rem_reg[31:0], (iter_reg == '0)};

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_acc && load_elem_last && load_vec_last) begin
                    state_next = S_LD_RD;
                end
            end
            S_LD_RD:   state_next = S_LD_WR;
            S_LD_WR: begin
                if (!j_last) begin
                    state_next = S_LD_RD;
                end else if (vi_reg == '0) begin
                    state_next = S_MAX;
                end else begin
                    state_next = S_DOT_RD;
                end
            end
            S_DOT_RD:  state_next = S_DOT_MUL;
            S_DOT_MUL: state_next = half_reg ? S_DOT_ACC : S_DOT_MUL;
            S_DOT_ACC: state_next = j_last ? S_UPD_RD : S_DOT_RD;
            S_UPD_RD:  state_next = S_UPD_MUL;
            S_UPD_MUL: state_next = half_reg ? S_UPD_WR : S_UPD_MUL;
            S_UPD_WR: begin
                if (!j_last) begin
                    state_next = S_UPD_RD;
                end else if (k_last) begin
                    state_next = S_MAX;
                end else begin
                    state_next = S_DOT_RD;
                end
            end
            S_MAX:     state_next = j_last ? S_SCALE : S_MAX;
            S_SCALE: begin
                priority if (m_reg == '0) begin
                    state_next = S_OUT_MUL;
                end else if (m_reg >= NORM_HI || m_reg < NORM_LO) begin
                    state_next = S_SCALE;
                end else begin
                    state_next = S_SQ_MUL;
                end
            end
            S_SQ_MUL:  state_next = half_reg ? S_SQ_ACC : S_SQ_MUL;
            S_SQ_ACC:  state_next = j_last ? S_SQRT : S_SQ_MUL;
            S_SQRT:    state_next = (iter_reg == SQRT_LAST) ? S_DIV : S_SQRT;
            S_DIV:     state_next = (iter_reg == DIV_LAST) ? S_OUT_MUL : S_DIV;
            S_OUT_MUL: state_next = half_reg ? S_OUT_LATCH : S_OUT_MUL;
            S_OUT_LATCH: state_next = S_OUT_SEND;
            S_OUT_SEND: begin
                if (m_tready) begin
                    if (!j_last) begin
                        state_next = S_OUT_MUL;
                    end else if (vi_last) begin
                        state_next = S_IDLE;
                    end else begin
                        state_next = S_LD_RD;
                    end
                end
            end
            default:   state_next = S_IDLE;
        endcase
    end

    // Datapath and counters
    always_comb begin
        vcount_next    = vcount_reg;
        vlen_next      = vlen_reg;
        load_vec_next  = load_vec_reg;
        load_elem_next = load_elem_reg;
        vi_next        = vi_reg;
        k_next         = k_reg;
        j_next         = j_reg;
        half_next      = half_reg;
        prod_lo_next   = prod_lo_reg;
        prod_next      = prod_reg;
        acc_next       = acc_reg;
        d_next         = d_reg;
        m_next         = m_reg;
        s_next         = s_reg;
        rem_next       = rem_reg;
        root_next      = root_reg;
        quo_next       = quo_reg;
        iter_next      = iter_reg;
        degen_next     = degen_reg;
        out_data_next  = out_data_reg;
        out_vidx_next  = out_vidx_reg;
        out_eidx_next  = out_eidx_reg;
        out_degen_next = out_degen_reg;
        out_last_next  = out_last_reg;
        out_valid_next = out_valid_reg;
        bas_we         = 1'b0;
        for (int e = 0; e < MAX_LENGTH; e++) begin
            work_next[e] = work_reg[e];
        end

        if (state_reg == S_DOT_MUL || state_reg == S_UPD_MUL ||
            state_reg == S_SQ_MUL || state_reg == S_OUT_MUL) begin
            half_next = !half_reg;
            if (!half_reg) begin
                prod_lo_next = mprod;
            end else begin
                prod_next = ({{15{mprod[64]}}, mprod} << 16) +
                            {{15{prod_lo_reg[64]}}, prod_lo_reg};
            end
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_acc) begin
                    if (load_elem_last) begin
                        load_elem_next = '0;
                        load_vec_next  = load_vec_last ? '0 : load_vec_reg + VW'(1);
                    end else begin
                        load_elem_next = load_elem_reg + LW'(1);
                    end
                    vi_next = '0;
                    j_next  = '0;
                end
            end
            S_LD_WR: begin
                work_next[j_reg] = {{2{in_rdata_reg[31]}}, in_rdata_reg, 14'b0};
                if (j_last) begin
                    j_next   = '0;
                    k_next   = '0;
                    m_next   = '0;
                    acc_next = '0;
                end else begin
                    j_next = j_reg + LW'(1);
                end
            end
            S_DOT_ACC: begin
                acc_next = acc_sum;
                if (j_last) begin
                    d_next = sat48(acc_sum);
                    j_next = '0;
                end else begin
                    j_next = j_reg + LW'(1);
                end
            end
            S_UPD_WR: begin
                work_next[j_reg] = sat48(upd_diff);
                if (j_last) begin
                    j_next   = '0;
                    k_next   = k_reg + VW'(1);
                    acc_next = '0;
                end else begin
                    j_next = j_reg + LW'(1);
                end
            end
            S_MAX: begin
                if (abs_w > m_reg) begin
                    m_next = abs_w;
                end
                j_next = j_last ? '0 : j_reg + LW'(1);
            end
            S_SCALE: begin
                priority if (m_reg == '0) begin
                    degen_next = 1'b1;
                    quo_next   = '0;
                    j_next     = '0;
                end else if (m_reg >= NORM_HI) begin
                    for (int e = 0; e < MAX_LENGTH; e++) begin
                        work_next[e] = work_reg[e] >>> 1;
                    end
                    m_next = m_reg >> 1;
                end else if (m_reg < NORM_LO) begin
                    for (int e = 0; e < MAX_LENGTH; e++) begin
                        work_next[e] = work_reg[e] <<< 1;
                    end
                    m_next = m_reg << 1;
                end else begin
                    degen_next = 1'b0;
                    s_next     = '0;
                    j_next     = '0;
                end
            end
            S_SQ_ACC: begin
                s_next = s_reg + prod_reg[63:0];
                if (j_last) begin
                    j_next    = '0;
                    rem_next  = '0;
                    root_next = '0;
                    iter_next = '0;
                end else begin
                    j_next = j_reg + LW'(1);
                end
            end
            S_SQRT: begin
                // One result bit per step, two radicand bits brought down each time.
                if (sq_rem >= {1'b0, sq_trial}) begin
                    rem_next  = sq_rem - {1'b0, sq_trial};
                    root_next = {root_reg[30:0], 1'b1};
                end else begin
                    rem_next  = sq_rem;
                    root_next = {root_reg[30:0], 1'b0};
                end
                s_next = {s_reg[61:0], 2'b00};
                if (iter_reg == SQRT_LAST) begin
                    iter_next = '0;
                    rem_next  = '0;
                    quo_next  = '0;
                end else begin
                    iter_next = iter_reg + 6'd1;
                end
            end
            S_DIV: begin
                // Dividend is 2^62: a single one bit followed by zeros.
                if (dv_rem >= {1'b0, root_reg}) begin
                    rem_next = {2'b00, dv_rem - {1'b0, root_reg}};
                    quo_next = {quo_reg[32:0], 1'b1};
                end else begin
                    rem_next = {2'b00, dv_rem};
                    quo_next = {quo_reg[32:0], 1'b0};
                end
                if (iter_reg == DIV_LAST) begin
                    iter_next = '0;
                    j_next    = '0;
                end else begin
                    iter_next = iter_reg + 6'd1;
                end
            end
            S_OUT_LATCH: begin
                out_data_next  = degen_reg ? 32'd0 : sat32(prod_reg[79:32]);
                out_vidx_next  = 3'(vi_reg);
                out_eidx_next  = 3'(j_reg);
                out_degen_next = degen_reg;
                out_last_next  = vi_last && j_last;
                out_valid_next = 1'b1;
                bas_we         = 1'b1;
            end
            S_OUT_SEND: begin
                if (m_tready) begin
                    out_valid_next = 1'b0;
                    if (!j_last) begin
                        j_next = j_reg + LW'(1);
                    end else begin
                        j_next  = '0;
                        vi_next = vi_last ? '0 : vi_reg + VW'(1);
                    end
                end
            end
            default: begin
            end
        endcase

        // Any register write drops a partly loaded set.
        if (cfg_acc) begin
            if (cfg_index == CFG_VCOUNT) begin
                vcount_next    = cfg_data;
                load_vec_next  = '0;
                load_elem_next = '0;
            end else if (cfg_index == CFG_VLEN) begin
                vlen_next      = cfg_data;
                load_vec_next  = '0;
                load_elem_next = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            vcount_reg    <= CFG_RESET_VALUE;
            vlen_reg      <= CFG_RESET_VALUE;
            load_vec_reg  <= '0;
            load_elem_reg <= '0;
            vi_reg        <= '0;
            k_reg         <= '0;
            j_reg         <= '0;
            half_reg      <= 1'b0;
            iter_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            vcount_reg    <= vcount_next;
            vlen_reg      <= vlen_next;
            load_vec_reg  <= load_vec_next;
            load_elem_reg <= load_elem_next;
            vi_reg        <= vi_next;
            k_reg         <= k_next;
            j_reg         <= j_next;
            half_reg      <= half_next;
            iter_reg      <= iter_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        prod_lo_reg   <= prod_lo_next;
        prod_reg      <= prod_next;
        acc_reg       <= acc_next;
        d_reg         <= d_next;
        m_reg         <= m_next;
        s_reg         <= s_next;
        rem_reg       <= rem_next;
        root_reg      <= root_next;
        quo_reg       <= quo_next;
        degen_reg     <= degen_next;
        out_data_reg  <= out_data_next;
        out_vidx_reg  <= out_vidx_next;
        out_eidx_reg  <= out_eidx_next;
        out_degen_reg <= out_degen_next;
        out_last_reg  <= out_last_next;
        for (int e = 0; e < MAX_LENGTH; e++) begin
            work_reg[e] <= work_next[e];
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            in_mem[{load_vec_reg, load_elem_reg}] <= s_tdata;
        end
        in_rdata_reg <= in_mem[{vi_reg, j_reg}];
    end

    always_ff @(posedge aclk) begin
        if (bas_we) begin
            bas_mem[{vi_reg, j_reg}] <= out_data_next;
        end
        bas_rdata_reg <= bas_mem[{k_reg, j_reg}];
    end

    // Loading and emitting never overlap.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input accepted while a result is pending");

    // The final result of a set returns the block to loading.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && m_tlast) |=> s_tready)
        else $error("block not idle after the last result");

    // The divider only runs on a non-zero norm.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DIV) |-> (root_reg != '0))
        else $error("division by a zero norm");

    // A degenerate vector carries zero components.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tdata[31:0] == '0))
        else $error("degenerate vector with non-zero component");

    // The root is only taken for a vector that was not flagged degenerate.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SQRT) |-> !degen_reg)
        else $error("square root on a degenerate vector");

endmodule

### dv/tb_gram_schmidt_orthonormalizer_unit.sv
// Self-checking testbench for gram_schmidt_orthonormalizer_unit: stream driver and monitor,
// with a bit-exact fixed-point predictor of modified Gram-Schmidt orthonormalisation.
// Depends on gso_pkg and the unit under test; needs no files or arguments.
`timescale 1ns / 1ps

module tb_gram_schmidt_orthonormalizer_unit;
    import gso_pkg::*;

    localparam int MAXV = 8;
    localparam int MAXL = 8;
    // An index that names no register: a write to it must change nothing.
    localparam logic [CFG_IDX_W-1:0] CFG_NO_REG = 4'd5;

    typedef struct {
        logic [31:0] comp;
        logic [2:0]  vec;
        logic [2:0]  elem;
        logic        degen;
        logic        last;
    } unit_item_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    // s_tdata, from bit 0: component[31:0]
    logic [IN_W-1:0]       s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    // m_tdata, from bit 0: unit_component[31:0], vector_index[34:32],
    // element_index[37:35], zero padding[39:38]
    logic [OUT_DATA_W-1:0] m_tdata;
    // m_tuser, from bit 0: degenerate
    logic                  m_tuser;
    logic                  m_tlast;

    gram_schmidt_orthonormalizer_unit dut (.*);

    always #5 aclk = ~aclk;

    // Predictor state: its own copy of the registers and of the vector stores.
    logic [3:0]  count_reg = 4'd8;
    logic [3:0]  length_reg = 4'd8;
    int          loaded = 0;
    longint      comp_mem [MAXV*MAXL];
    longint      unit_mem [MAXV*MAXL];
    unit_item_t  unit_due [$];

    logic [31:0] feed [$];
    int          items_queued = 0;
    int          items_accepted = 0;
    int          results_seen = 0;
    int          sets_done = 0;
    int          failures = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          hold_left = 0;

    function automatic int clip(logic [3:0] v, int lim);
        if (v == 0) return 1;
        return (v > lim) ? lim : int'(v);
    endfunction

    function automatic longint sat(longint x, int bits);
        longint hi;
        hi = (64'sd1 <<< (bits - 1)) - 1;
        if (x > hi) return hi;
        if (x < -hi - 1) return -hi - 1;
        return x;
    endfunction

    // floor(a*b / 2^30), splitting b so that no product overflows 64 bits.
    function automatic longint mul_q30(longint a, longint b);
        longint bh, bl;
        bh = b >>> 16;
        bl = b - bh * 65536;
        return (a * bh + ((a * bl) >>> 16)) >>> 14;
    endfunction

    function automatic longint unsigned root_floor(longint unsigned s);
        longint unsigned r, t;
        r = 0;
        for (int i = 31; i >= 0; i--) begin
            t = r | (64'd1 << i);
            if (t * t <= s) r = t;
        end
        return r;
    endfunction

    // Runs the whole orthonormalisation once the last component of a set is in,
    // queueing every unit component it produces in output order.
    function automatic void orthonormalise(int nv, int nl);
        longint w [MAXL];
        longint d, m, a, rcp, x, u;
        longint unsigned s;
        int r;
        longint scale;
        logic degen;
        unit_item_t it;
        for (int i = 0; i < nv; i++) begin
            for (int j = 0; j < nl; j++) w[j] = comp_mem[i*MAXL + j] * 16384;
            for (int k = 0; k < i; k++) begin
                d = 0;
                for (int j = 0; j < nl; j++) d += mul_q30(w[j], unit_mem[k*MAXL + j]);
                d = sat(d, 48);
                for (int j = 0; j < nl; j++)
                    w[j] = sat(w[j] - mul_q30(d, unit_mem[k*MAXL + j]), 48);
            end
            m = 0;
            for (int j = 0; j < nl; j++) begin
                a = (w[j] < 0) ? -w[j] : w[j];
                if (a > m) m = a;
            end
            degen = (m == 0);
            rcp = 0;
            if (!degen) begin
                // Bring the largest magnitude into [2^29, 2^30) before the root.
                r = 0;
                scale = 1;
                while ((m >>> r) >= (64'sd1 <<< 30)) r++;
                if (r == 0) while (m * scale < (64'sd1 <<< 29)) scale *= 2;
                s = 0;
                for (int j = 0; j < nl; j++) begin
                    x = (r != 0) ? (w[j] >>> r) : w[j] * scale;
                    w[j] = x;
                    s += longint'(x * x);
                end
                rcp = longint'((64'd1 << 62) / root_floor(s));
            end
            for (int j = 0; j < nl; j++) begin
                u = degen ? 0 : sat((w[j] * rcp) >>> 32, 32);
                unit_mem[i*MAXL + j] = u;
                it.comp  = u[31:0];
                it.vec   = i[2:0];
                it.elem  = j[2:0];
                it.degen = degen;
                it.last  = (i == nv - 1) && (j == nl - 1);
                unit_due.insert(unit_due.size(), it);
            end
        end
        sets_done++;
    endfunction

    function automatic void take_component(logic [31:0] c);
        int nv, nl;
        nv = clip(count_reg, MAXV);
        nl = clip(length_reg, MAXL);
        if (loaded >= nv * nl) loaded = 0;
        comp_mem[(loaded / nl) * MAXL + (loaded % nl)] = longint'($signed(c));
        loaded++;
        if (loaded == nv * nl) begin
            loaded = 0;
            orthonormalise(nv, nl);
        end
    endfunction

    // Driver: a valid item is held until accepted, and prediction happens on acceptance.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                take_component(s_tdata);
                items_accepted++;
            end
            if (!s_tvalid || s_tready) begin
                if (feed.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= feed.pop_front();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: random back-pressure, or a long hold-off when one is requested.
    always @(posedge aclk) begin
        unit_item_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                results_seen++;
                if (unit_due.size() == 0) begin
                    $error("unexpected result item %h", m_tdata);
                    failures++;
                end else begin
                    want = unit_due.pop_front();
                    if (m_tdata[31:0] !== want.comp) begin
                        $error("unit_component: expected %h, got %h", want.comp, m_tdata[31:0]);
                        failures++;
                    end
                    if (m_tdata[34:32] !== want.vec) begin
                        $error("vector_index: expected %0d, got %0d", want.vec, m_tdata[34:32]);
                        failures++;
                    end
                    if (m_tdata[37:35] !== want.elem) begin
                        $error("element_index: expected %0d, got %0d", want.elem,
                               m_tdata[37:35]);
                        failures++;
                    end
                    if (m_tuser !== want.degen) begin
                        $error("degenerate: expected %b, got %b", want.degen, m_tuser);
                        failures++;
                    end
                    if (m_tlast !== want.last) begin
                        $error("last: expected %b, got %b", want.last, m_tlast);
                        failures++;
                    end
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Register write; the predictor follows it at the handshake edge.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [3:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        if (idx == CFG_VCOUNT) begin
            count_reg = val;
            loaded = 0;
        end else if (idx == CFG_VLEN) begin
            length_reg = val;
            loaded = 0;
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic send(logic [31:0] c);
        feed.insert(feed.size(), c);
        items_queued++;
    endtask

    // Sender pauses here until every item is in and every result is out.
    task automatic drain();
        while (items_accepted != items_queued || unit_due.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    task automatic config_set(logic [3:0] nv, logic [3:0] nl);
        write_reg(CFG_VCOUNT, nv);
        write_reg(CFG_VLEN, nl);
    endtask

    function automatic logic [31:0] random_component(int flavour);
        case (flavour)
            0: return $urandom;
            1: return 32'($signed($urandom_range(131072)) - 65536);
            default: return 32'($signed($urandom_range(1 << 24)) - (1 << 23));
        endcase
    endfunction

    // One full set with random content; some vectors copy an earlier vector of the set,
    // so that a vector vanishes after projection removal.
    task automatic random_set(int nv, int nl);
        logic [31:0] held [MAXV*MAXL];
        int flavour, src;
        flavour = $urandom_range(2);
        for (int i = 0; i < nv; i++) begin
            src = (i > 0 && $urandom_range(3) == 0) ? $urandom_range(i - 1) : -1;
            for (int j = 0; j < nl; j++) begin
                if ($urandom_range(9) == 0)
                    held[i*MAXL + j] = 32'd0;
                else if (src >= 0)
                    held[i*MAXL + j] = held[src*MAXL + j];
                else
                    held[i*MAXL + j] = random_component(flavour);
                send(held[i*MAXL + j]);
            end
        end
    endtask

    initial begin
        int nv, nl, phase;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Single components at the field extremes; a zero one is degenerate.
        config_set(4'd1, 4'd1);
        send(32'h7FFF_FFFF);
        send(32'h8000_0000);
        send(32'h0000_0000);
        drain();

        // Out-of-range counts: fifteen vectors act as eight and zero length as one, so every vector
        // after the first collapses to zero; then a zero count acts as one, length 15 as eight.
        config_set(4'd15, 4'd0);
        for (int i = 0; i < 8; i++) send(i[0] ? 32'hFFFF_0000 : 32'h0001_0000 + i);
        drain();
        config_set(4'd0, 4'd15);
        for (int i = 0; i < 8; i++) send(32'h0000_0001 << (i * 4));
        drain();

        // A partly loaded set is dropped by a register write.
        config_set(4'd2, 4'd2);
        send(32'h1234_5678);
        send(32'h8765_4321);
        send(32'h0F0F_0F0F);
        drain();
        config_set(4'd2, 4'd2);
        // A write to a missing register keeps the partial set.
        send(32'h0003_0000);
        send(32'h0004_0000);
        drain();
        write_reg(CFG_NO_REG, 4'd3);
        send(32'hFFFA_0000);
        send(32'hFFF8_0000);
        drain();

        // Long receiver hold-off while the sender offers a second set, so the
        // block fills its output and refuses input.
        recv_stall_pct = 0;
        hold_left = 3000;
        random_set(2, 2);
        random_set(2, 2);
        drain();

        // Random sets over four idling phases, mostly small, with the largest once.
        while (items_queued < 240) begin
            phase = (items_queued - 34) * 4 / 206;
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 74; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 74; end
                default: begin send_idle_pct = 9; recv_stall_pct = 9; end
            endcase
            if (phase == 1 && count_reg != 8) begin
                nv = 8;
                nl = 8;
            end else begin
                nv = $urandom_range(4, 1);
                nl = $urandom_range(4, 1);
            end
            config_set(nv[3:0], nl[3:0]);
            random_set(nv, nl);
            drain();
        end

        $display("Covered %0d components in %0d sets, %0d unit components checked,",
                 items_accepted, sets_done, results_seen);
        $display("with field extremes, clipped registers, discarded partial sets and stalls.");
        if (failures == 0) begin
            $display("gram_schmidt_orthonormalizer_unit: match");
        end else begin
            $display("gram_schmidt_orthonormalizer_unit: mismatch");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("gram_schmidt_orthonormalizer_unit: mismatch");
        $finish;
    end

endmodule

### filelist.f
hdl/gso_pkg.sv
hdl/gram_schmidt_orthonormalizer_unit.sv
dv/tb_gram_schmidt_orthonormalizer_unit.sv
